[rtl/dual_pid_differential_drive_macros.svh]
// assertion macros for the dual pid differential drive block
`ifndef DUAL_PID_DIFFERENTIAL_DRIVE_MACROS_SVH
`define DUAL_PID_DIFFERENTIAL_DRIVE_MACROS_SVH

// checked outside reset
`define DPDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DPDD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dpdd_pkg.sv]
// types, widths and constants shared by the dual pid differential drive files
`default_nettype none

package dpdd_pkg;

  localparam int POS_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int MINP_W    = 7;
  localparam int WIN_W     = 8;
  localparam int POWER_W   = 8;
  localparam int INTEG_W   = 10;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam int PAIR_W    = POS_W + 1;
  localparam int SUM_W     = POS_W + 2;
  localparam int ERR_W     = POS_W + 1;
  localparam int DER_W     = ERR_W + 1;
  localparam int PROD_P_W  = ERR_W + GAIN_W;
  localparam int PROD_D_W  = DER_W + GAIN_W;
  localparam int PROD_I_W  = INTEG_W + GAIN_W;
  localparam int RAW_W     = PROD_D_W + 2;
  localparam int MIX_W     = RAW_W + 1;

  localparam int TOLERANCE  = 5;
  localparam int TARGET_MIN = 1;

  localparam logic [MINP_W-1:0] POWER_MAX     = 7'd100;
  localparam logic [MINP_W-1:0] MIN_POWER_RST = 7'd20;
  localparam logic [WIN_W-1:0]  WINDOW_RST    = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATERAL_KP      = 4'd0,
    CFG_LATERAL_KI      = 4'd1,
    CFG_LATERAL_KD      = 4'd2,
    CFG_TURN_KP         = 4'd3,
    CFG_TURN_KI         = 4'd4,
    CFG_TURN_KD         = 4'd5,
    CFG_MIN_POWER       = 4'd6,
    CFG_INTEGRAL_WINDOW = 4'd7
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/dpdd_cfg_if.sv]
// register write channel
`default_nettype none

interface dpdd_cfg_if import dpdd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/dpdd_tick_if.sv]
// control tick input channel
`default_nettype none

interface dpdd_tick_if import dpdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_left_front;
  logic signed [POS_W-1:0] pos_right_front;
  logic signed [POS_W-1:0] pos_left_back;
  logic signed [POS_W-1:0] pos_right_back;
  logic signed [POS_W-1:0] lateral_target;
  logic signed [POS_W-1:0] turn_target;

  modport source (
    output valid, output pos_left_front, output pos_right_front,
    output pos_left_back, output pos_right_back, output lateral_target,
    output turn_target, input ready
  );
  modport sink (
    input valid, input pos_left_front, input pos_right_front,
    input pos_left_back, input pos_right_back, input lateral_target,
    input turn_target, output ready
  );
endinterface

`default_nettype wire

[rtl/dpdd_power_if.sv]
// drive power output channel
`default_nettype none

interface dpdd_power_if import dpdd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] left_power;
  logic signed [POWER_W-1:0] right_power;
  logic                      done_res;

  modport source (
    output valid, output left_power, output right_power, output done_res, input ready
  );
  modport sink (
    input valid, input left_power, input right_power, input done_res, output ready
  );
endinterface

`default_nettype wire

[rtl/dpdd_integ.sv]
// windowed and clamped integral update for one loop
`default_nettype none

module dpdd_integ import dpdd_pkg::*; #(
  parameter int CAP = 300
) (
  input  logic signed [INTEG_W-1:0] acc,
  input  logic signed [ERR_W-1:0]   err,
  input  logic        [WIN_W-1:0]   window,
  output logic signed [INTEG_W-1:0] acc_next
);

  localparam logic signed [INTEG_W:0] CAP_HI = (INTEG_W + 1)'(CAP);
  localparam logic signed [INTEG_W:0] CAP_LO = -CAP_HI;

  logic        [ERR_W-1:0] err_mag;
  logic signed [INTEG_W:0] sum;

  always_comb begin
    err_mag = err[ERR_W-1] ? -err : err;
    sum     = (INTEG_W + 1)'(acc) + $signed(err[INTEG_W:0]);
    if (err_mag >= ERR_W'(window)) begin
      acc_next = '0;
    end else if (sum > CAP_HI) begin
      acc_next = CAP_HI[INTEG_W-1:0];
    end else if (sum < CAP_LO) begin
      acc_next = CAP_LO[INTEG_W-1:0];
    end else begin
      acc_next = sum[INTEG_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/dpdd_drive.sv]
// mix value to rounded, floored and saturated drive percent
`default_nettype none

module dpdd_drive import dpdd_pkg::*; (
  input  logic signed [MIX_W-1:0]   mix,
  input  logic        [MINP_W-1:0]  min_power,
  output logic signed [POWER_W-1:0] power
);

  logic [MIX_W-1:0] mag_rnd;
  logic [MIX_W-9:0] mag;
  logic [MINP_W-1:0] low;
  logic [MINP_W-1:0] sat;

  always_comb begin
    // |mix| + 128, negative side as ~mix + 1 + 128
    mag_rnd = mix[MIX_W-1] ? (~mix + MIX_W'(129)) : (mix + MIX_W'(128));
    mag     = mag_rnd[MIX_W-1:8];
    low     = (mag[MINP_W-1:0] < min_power) ? min_power : mag[MINP_W-1:0];
    if (mag[MIX_W-9:MINP_W] != '0) begin
      sat = POWER_MAX;
    end else begin
      sat = (low > POWER_MAX) ? POWER_MAX : low;
    end
    power = mix[MIX_W-1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

endmodule

`default_nettype wire

[rtl/dual_pid_differential_drive.sv]
// dual pid differential drive: lateral and turn loops mixed into side powers
// an accepted tick passes stages 0 to 3 and then the output register
// throughput: one tick per cycle through a five-register pipeline, unless power.ready stalls it
// reset: gains clear, min power 20, window 3, errors and integrals zero
`default_nettype none
`include "dual_pid_differential_drive_macros.svh"

module dual_pid_differential_drive import dpdd_pkg::*; #(
  parameter int INTEGRAL_CAP = 300
) (
  input logic              clk,
  input logic              rst,
  dpdd_cfg_if.sink         cfg,
  dpdd_tick_if.sink        tick,
  dpdd_power_if.source     power
);

  localparam logic signed [INTEG_W-1:0] CAP_S = INTEG_W'(INTEGRAL_CAP);

  // registers
  logic signed [GAIN_W-1:0] lateral_kp, lateral_ki, lateral_kd;
  logic signed [GAIN_W-1:0] turn_kp, turn_ki, turn_kd;
  logic        [MINP_W-1:0] min_power;
  logic        [WIN_W-1:0]  integral_window;

  // loop state
  logic signed [DER_W-1:0]   last_lateral_error, last_turn_error;
  logic signed [INTEG_W-1:0] lateral_integral, turn_integral;

  logic adv;
  logic v0, v1, v2, v3;

  // stage 0
  logic signed [POS_W-1:0] lf0, rf0, lb0, rb0, lat_t0, turn_t0;

  // stage 1 logic
  logic signed [SUM_W-1:0]   sum_all, sum_adj, diff, diff_adj;
  logic signed [PAIR_W-1:0]  left_pair, right_pair;
  logic signed [POS_W-1:0]   avg, tdiff;
  logic signed [ERR_W-1:0]   lerr_c, terr_c, lat_ext, turn_ext;
  logic signed [DER_W-1:0]   lder_c, tder_c;
  logic        [ERR_W-1:0]   lat_abs, turn_abs, lerr_abs, terr_abs;
  logic signed [INTEG_W-1:0] lint_c, tint_c;
  logic                      done_c;

  // stage 1
  logic signed [ERR_W-1:0]   lerr1, terr1;
  logic signed [DER_W-1:0]   lder1, tder1;
  logic signed [INTEG_W-1:0] lint1, tint1;
  logic                      done1;

  // stage 2
  logic signed [PROD_P_W-1:0] p_lkp, p_tkp;
  logic signed [PROD_D_W-1:0] p_lkd, p_tkd;
  logic signed [PROD_I_W-1:0] p_lki, p_tki;
  logic                       done2;

  // stage 3
  logic signed [RAW_W-1:0] lat_raw3, turn_raw3;
  logic                    done3;

  logic signed [MIX_W-1:0]   mix_l, mix_r;
  logic signed [POWER_W-1:0] power_l, power_r;

  assign cfg.ready  = 1'b1;
  assign adv        = !power.valid || power.ready;
  assign tick.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      lateral_kp      <= '0;
      lateral_ki      <= '0;
      lateral_kd      <= '0;
      turn_kp         <= '0;
      turn_ki         <= '0;
      turn_kd         <= '0;
      min_power       <= MIN_POWER_RST;
      integral_window <= WINDOW_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LATERAL_KP:      lateral_kp      <= cfg.data;
        CFG_LATERAL_KI:      lateral_ki      <= cfg.data;
        CFG_LATERAL_KD:      lateral_kd      <= cfg.data;
        CFG_TURN_KP:         turn_kp         <= cfg.data;
        CFG_TURN_KI:         turn_ki         <= cfg.data;
        CFG_TURN_KD:         turn_kd         <= cfg.data;
        CFG_MIN_POWER:       min_power       <= cfg.data[MINP_W-1:0];
        CFG_INTEGRAL_WINDOW: integral_window <= cfg.data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // errors, derivatives, integrals and done test
  always_comb begin
    sum_all    = SUM_W'(lf0) + SUM_W'(rf0) + SUM_W'(lb0) + SUM_W'(rb0);
    sum_adj    = sum_all + (sum_all[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
    avg        = sum_adj[SUM_W-1:2];
    left_pair  = PAIR_W'(lf0) + PAIR_W'(lb0);
    right_pair = PAIR_W'(rf0) + PAIR_W'(rb0);
    diff       = SUM_W'(left_pair) - SUM_W'(right_pair);
    diff_adj   = diff + (diff[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
    tdiff      = diff_adj[SUM_W-1:2];
    lerr_c     = ERR_W'(lat_t0) - ERR_W'(avg);
    terr_c     = ERR_W'(turn_t0) - ERR_W'(tdiff);
    lder_c     = DER_W'(lerr_c) - last_lateral_error;
    tder_c     = DER_W'(terr_c) - last_turn_error;
    lat_ext    = ERR_W'(lat_t0);
    turn_ext   = ERR_W'(turn_t0);
    lat_abs    = lat_ext[ERR_W-1] ? -lat_ext : lat_ext;
    turn_abs   = turn_ext[ERR_W-1] ? -turn_ext : turn_ext;
    lerr_abs   = lerr_c[ERR_W-1] ? -lerr_c : lerr_c;
    terr_abs   = terr_c[ERR_W-1] ? -terr_c : terr_c;
    done_c     = (lat_abs > ERR_W'(TARGET_MIN) && lerr_abs < ERR_W'(TOLERANCE)) ||
                 (turn_abs > ERR_W'(TARGET_MIN) && terr_abs < ERR_W'(TOLERANCE));
  end

  dpdd_integ #(.CAP(INTEGRAL_CAP)) u_lat_integ (
    .acc      (lateral_integral),
    .err      (lerr_c),
    .window   (integral_window),
    .acc_next (lint_c)
  );

  dpdd_integ #(.CAP(INTEGRAL_CAP)) u_turn_integ (
    .acc      (turn_integral),
    .err      (terr_c),
    .window   (integral_window),
    .acc_next (tint_c)
  );

  assign mix_l = MIX_W'(lat_raw3) + MIX_W'(turn_raw3);
  assign mix_r = MIX_W'(lat_raw3) - MIX_W'(turn_raw3);

  dpdd_drive u_drive_left (
    .mix       (mix_l),
    .min_power (min_power),
    .power     (power_l)
  );

  dpdd_drive u_drive_right (
    .mix       (mix_r),
    .min_power (min_power),
    .power     (power_r)
  );

  // pipeline control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0                 <= 1'b0;
      v1                 <= 1'b0;
      v2                 <= 1'b0;
      v3                 <= 1'b0;
      power.valid        <= 1'b0;
      last_lateral_error <= '0;
      last_turn_error    <= '0;
      lateral_integral   <= '0;
      turn_integral      <= '0;
    end else if (adv) begin
      v0          <= tick.valid;
      v1          <= v0;
      v2          <= v1;
      v3          <= v2;
      power.valid <= v3;
      if (v0) begin
        last_lateral_error <= DER_W'(lerr_c);
        last_turn_error    <= DER_W'(terr_c);
        lateral_integral   <= lint_c;
        turn_integral      <= tint_c;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      lf0     <= tick.pos_left_front;
      rf0     <= tick.pos_right_front;
      lb0     <= tick.pos_left_back;
      rb0     <= tick.pos_right_back;
      lat_t0  <= tick.lateral_target;
      turn_t0 <= tick.turn_target;

      lerr1 <= lerr_c;
      terr1 <= terr_c;
      lder1 <= lder_c;
      tder1 <= tder_c;
      lint1 <= lint_c;
      tint1 <= tint_c;
      done1 <= done_c;

      p_lkp <= PROD_P_W'(lerr1) * PROD_P_W'(lateral_kp);
      p_lkd <= PROD_D_W'(lder1) * PROD_D_W'(lateral_kd);
      p_lki <= PROD_I_W'(lint1) * PROD_I_W'(lateral_ki);
      p_tkp <= PROD_P_W'(terr1) * PROD_P_W'(turn_kp);
      p_tkd <= PROD_D_W'(tder1) * PROD_D_W'(turn_kd);
      p_tki <= PROD_I_W'(tint1) * PROD_I_W'(turn_ki);
      done2 <= done1;

      lat_raw3  <= RAW_W'(p_lkp) + RAW_W'(p_lkd) + RAW_W'(p_lki);
      turn_raw3 <= RAW_W'(p_tkp) + RAW_W'(p_tkd) + RAW_W'(p_tki);
      done3     <= done2;

      power.left_power  <= power_l;
      power.right_power <= power_r;
      power.done_res    <= done3;
    end
  end

  `DPDD_ASSERT(left_range_a,
    power.valid |-> (power.left_power <= 8'sd100 && power.left_power >= -8'sd100),
    "left power out of range")
  `DPDD_ASSERT(right_range_a,
    power.valid |-> (power.right_power <= 8'sd100 && power.right_power >= -8'sd100),
    "right power out of range")
  `DPDD_ASSERT(integ_cap_a,
    (lateral_integral <= CAP_S && lateral_integral >= -CAP_S &&
     turn_integral <= CAP_S && turn_integral >= -CAP_S),
    "integral beyond cap")
  `DPDD_ASSERT(stall_hold_a,
    !adv |=> ($stable(lateral_integral) && $stable(last_turn_error)),
    "loop state moved during stall")
  `DPDD_ASSERT_RST(reset_empty_a, rst |=> !power.valid, "result offered right after reset")

endmodule

`default_nettype wire
